>>> rtl/core/scli_pkg.sv
`default_nettype none

package scli_pkg;

    // field widths
    localparam int SAMPLE_W      = 10;
    localparam int LEVEL_W       = 8;
    localparam int OWNER_W       = 3;
    localparam int TIME_W        = 32;
    localparam int THRESH_W      = 10;
    localparam int HOLD_W        = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int SAMPLE_FIELDS = 5;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [OWNER_W-1:0]  owner_t;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACT_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME     = CFG_INDEX_W'(1);

    // item kinds
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // colour map constants
    localparam sample_t MID_POINT  = SAMPLE_W'(1023 / 2);
    localparam level_t  LEVEL_MAX  = 8'd255;
    localparam level_t  BLUE_FLOOR = 8'd20;
    localparam owner_t  NO_OWNER   = 3'd5;

    // scan or fade tick
    typedef struct packed {
        logic              mode;
        sample_t           sample_0;
        sample_t           sample_1;
        sample_t           sample_2;
        sample_t           sample_3;
        sample_t           sample_4;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    // one led update
    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
        logic   display_on;
        owner_t active_slider;
        logic   last;
    } out_item_t;

    // outcome of one slider evaluation
    typedef struct packed {
        logic   wrote;
        owner_t owner;
        level_t red;
        level_t green;
        level_t blue;
    } eval_res_t;

endpackage

`default_nettype wire

>>> rtl/core/scli_eval.sv
`default_nettype none

module scli_eval
    import scli_pkg::*;
#(
    parameter int SLIDER_COUNT = 5
)
(
    input  sample_t               cur [SLIDER_COUNT],
    input  sample_t               prev [SLIDER_COUNT],
    input  logic [THRESH_W-1:0]   threshold,
    input  logic                  active,
    input  owner_t                owner,
    output eval_res_t             result
);

    localparam level_t BLUE_SPAN = LEVEL_MAX - BLUE_FLOOR;

    logic [SLIDER_COUNT-1:0] trig;
    logic                    found;
    owner_t                  first_idx;
    logic                    own_trig;
    owner_t                  sel;
    sample_t                 value;

    // per-slider change detection
    for (genvar g = 0; g < SLIDER_COUNT; g++)
    begin : g_trig
        sample_t diff;
        assign diff    = (cur[g] > prev[g]) ? (cur[g] - prev[g]) : (prev[g] - cur[g]);
        assign trig[g] = diff > threshold;
    end

    // lowest moving slider, or the current owner if it moved
    always_comb
    begin
        found     = 1'b0;
        first_idx = '0;
        own_trig  = 1'b0;
        for (int i = 0; i < SLIDER_COUNT; i++)
        begin
            if (trig[i] && !found)
            begin
                found     = 1'b1;
                first_idx = owner_t'(i);
            end
            if (trig[i] && (owner == owner_t'(i)))
            begin
                own_trig = 1'b1;
            end
        end
    end

    assign sel = active ? owner : first_idx;

    // sample of the winning slider
    always_comb
    begin
        value = '0;
        for (int i = 0; i < SLIDER_COUNT; i++)
        begin
            if (sel == owner_t'(i))
            begin
                value = cur[i];
            end
        end
    end

    // lower half: v*255/511, 511 = 2^9-1 so one correction step
    logic [17:0] lo_prod;
    logic [7:0]  lo_q1;
    logic [9:0]  lo_rem;
    level_t      lo_q;

    assign lo_prod = ({8'b0, value} << 8) - {8'b0, value};
    assign lo_q1   = lo_prod[16:9];
    assign lo_rem  = {1'b0, lo_prod[8:0]} + {2'b0, lo_q1};
    assign lo_q    = lo_q1 + {7'b0, (lo_rem >= 10'd511)};

    // upper half: span is 512, so division is a shift
    sample_t     hi_d;
    logic [17:0] hi_green;
    logic [16:0] hi_blue;

    assign hi_d     = value - MID_POINT;
    assign hi_green = ({8'b0, hi_d} << 8) - {8'b0, hi_d};
    assign hi_blue  = 17'(hi_d) * 17'(BLUE_SPAN);

    always_comb
    begin
        result.wrote = active ? own_trig : found;
        result.owner = sel;
        if (value < MID_POINT)
        begin
            result.red   = LEVEL_MAX - lo_q;
            result.green = lo_q;
            result.blue  = '0;
        end
        else
        begin
            result.red   = '0;
            result.green = LEVEL_MAX - hi_green[16:9];
            result.blue  = BLUE_FLOOR + hi_blue[16:9];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/slider_change_led_indicator_unit.sv
`default_nettype none
// A result passes through the input register and then the result queue before
// it is offered. One item per cycle is taken while the result queue has room;
// an item that ends a fade and lights a new colour gives two results, a dark
// frame and then the new colour, from the four-entry queue.
// Reset clears all slider and led state; threshold resets to 10, hold to 100 ms.

module slider_change_led_indicator_unit
    import scli_pkg::*;
#(
    parameter int SLIDER_COUNT = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [THRESH_W-1:0]    THRESH_RESET      = THRESH_W'(10);
    localparam logic [HOLD_W-1:0]      HOLD_RESET        = HOLD_W'(100);
    localparam int                     FIFO_DEPTH        = 4;
    localparam int                     PTR_W             = $clog2(FIFO_DEPTH);
    localparam int                     CNT_W             = $clog2(FIFO_DEPTH + 1);

    // configuration
    logic [THRESH_W-1:0] threshold_reg;
    logic [HOLD_W-1:0]   hold_time_reg;

    // input register
    logic     in_full_reg;
    in_item_t in_item_reg;

    // display state
    sample_t           prev_reg [SLIDER_COUNT];
    sample_t           cur_reg [SLIDER_COUNT];
    level_t            red_reg, green_reg, blue_reg;
    logic              active_reg;
    owner_t            owner_reg;
    logic [TIME_W-1:0] hold_start_reg;
    logic              fading_reg;
    logic              pending_reg;

    // result queue
    out_item_t         fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    // next values
    sample_t           prev_next [SLIDER_COUNT];
    sample_t           cur_next [SLIDER_COUNT];
    level_t            red_next, green_next, blue_next;
    logic              active_next;
    owner_t            owner_next;
    logic [TIME_W-1:0] hold_start_next;
    logic              fading_next;
    logic              pending_next;
    logic [1:0]        push_cnt;
    out_item_t         res0, res1;

    logic room, fire, in_take, out_take;

    // handshakes
    assign room      = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign fire      = in_full_reg && room;
    assign in_stall  = in_full_reg && !room;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = count_reg != '0;
    assign out_data  = fifo_reg[rd_ptr_reg];
    assign out_take  = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    // samples of this scan, missing sliders read zero
    sample_t in_samples [SAMPLE_FIELDS];
    sample_t new_s [SLIDER_COUNT];

    assign in_samples[0] = in_item_reg.sample_0;
    assign in_samples[1] = in_item_reg.sample_1;
    assign in_samples[2] = in_item_reg.sample_2;
    assign in_samples[3] = in_item_reg.sample_3;
    assign in_samples[4] = in_item_reg.sample_4;

    for (genvar g = 0; g < SLIDER_COUNT; g++)
    begin : g_new
        if (g < SAMPLE_FIELDS)
        begin : g_field
            assign new_s[g] = in_samples[g];
        end
        else
        begin : g_zero
            assign new_s[g] = '0;
        end
    end

    // hold expiry and fade step
    logic              is_scan;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic              levels_nz;
    level_t            red_dec, green_dec, blue_dec;

    assign is_scan   = (in_item_reg.mode == MODE_SCAN);
    assign elapsed   = in_item_reg.now_ms - hold_start_reg;
    assign expired   = active_reg && (elapsed > {{(TIME_W-HOLD_W){1'b0}}, hold_time_reg});
    assign levels_nz = (red_reg != '0) || (green_reg != '0) || (blue_reg != '0);
    assign red_dec   = red_reg - {7'b0, (red_reg != '0)};
    assign green_dec = green_reg - {7'b0, (green_reg != '0)};
    assign blue_dec  = blue_reg - {7'b0, (blue_reg != '0)};

    // evaluation operands: a scan uses its fresh samples, a fade end the stored ones
    sample_t   eval_cur [SLIDER_COUNT];
    sample_t   eval_prev [SLIDER_COUNT];
    logic      eval_active;
    owner_t    eval_owner;
    eval_res_t ev;

    always_comb
    begin
        for (int i = 0; i < SLIDER_COUNT; i++)
        begin
            eval_cur[i]  = is_scan ? new_s[i] : cur_reg[i];
            eval_prev[i] = is_scan ? cur_reg[i] : prev_reg[i];
        end
        eval_active = is_scan && active_reg && !expired;
        eval_owner  = eval_active ? owner_reg : NO_OWNER;
    end

    scli_eval #(
        .SLIDER_COUNT (SLIDER_COUNT)
    ) u_eval (
        .cur       (eval_cur),
        .prev      (eval_prev),
        .threshold (threshold_reg),
        .active    (eval_active),
        .owner     (eval_owner),
        .result    (ev)
    );

    // state update and results of one item
    always_comb
    begin
        for (int i = 0; i < SLIDER_COUNT; i++)
        begin
            prev_next[i] = prev_reg[i];
            cur_next[i]  = cur_reg[i];
        end
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        active_next     = active_reg;
        owner_next      = owner_reg;
        hold_start_next = hold_start_reg;
        fading_next     = fading_reg;
        pending_next    = pending_reg;
        push_cnt        = 2'd1;
        res1            = '0;

        if (is_scan)
        begin
            if (!fading_reg)
            begin
                for (int i = 0; i < SLIDER_COUNT; i++)
                begin
                    prev_next[i] = cur_reg[i];
                    cur_next[i]  = new_s[i];
                end
                if (expired && levels_nz)
                begin
                    fading_next  = 1'b1;
                    pending_next = 1'b1;
                end
                else
                begin
                    if (expired)
                    begin
                        red_next    = '0;
                        green_next  = '0;
                        blue_next   = '0;
                        active_next = 1'b0;
                        owner_next  = NO_OWNER;
                        fading_next = 1'b0;
                    end
                    if (ev.wrote)
                    begin
                        red_next        = ev.red;
                        green_next      = ev.green;
                        blue_next       = ev.blue;
                        active_next     = 1'b1;
                        owner_next      = ev.owner;
                        hold_start_next = in_item_reg.now_ms;
                    end
                end
            end
        end
        else if (fading_reg)
        begin
            red_next   = red_dec;
            green_next = green_dec;
            blue_next  = blue_dec;
            if ((red_dec == '0) && (green_dec == '0) && (blue_dec == '0))
            begin
                active_next  = 1'b0;
                owner_next   = NO_OWNER;
                fading_next  = 1'b0;
                pending_next = 1'b0;
                if (pending_reg && ev.wrote)
                begin
                    red_next        = ev.red;
                    green_next      = ev.green;
                    blue_next       = ev.blue;
                    active_next     = 1'b1;
                    owner_next      = ev.owner;
                    hold_start_next = in_item_reg.now_ms;
                    push_cnt        = 2'd2;
                end
            end
        end

        // the dark frame leads when a fade ends in a new colour
        if (push_cnt == 2'd2)
        begin
            res0.red           = '0;
            res0.green         = '0;
            res0.blue          = '0;
            res0.display_on    = 1'b0;
            res0.active_slider = NO_OWNER;
            res0.last          = 1'b0;
        end
        else
        begin
            res0.red           = red_next;
            res0.green         = green_next;
            res0.blue          = blue_next;
            res0.display_on    = active_next;
            res0.active_slider = owner_next;
            res0.last          = 1'b1;
        end
        res1.red           = red_next;
        res1.green         = green_next;
        res1.blue          = blue_next;
        res1.display_on    = active_next;
        res1.active_slider = owner_next;
        res1.last          = 1'b1;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESH_RESET;
            hold_time_reg  <= HOLD_RESET;
            in_full_reg    <= 1'b0;
            for (int i = 0; i < SLIDER_COUNT; i++)
            begin
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            active_reg     <= 1'b0;
            owner_reg      <= NO_OWNER;
            hold_start_reg <= '0;
            fading_reg     <= 1'b0;
            pending_reg    <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            // register writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ACT_THRESHOLD: threshold_reg <= cfg_data[THRESH_W-1:0];
                    REG_HOLD_TIME:     hold_time_reg <= cfg_data[HOLD_W-1:0];
                    default:           ;
                endcase
            end

            // input stage occupancy
            if (in_take)
            begin
                in_full_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_full_reg <= 1'b0;
            end

            // commit one item
            if (fire)
            begin
                for (int i = 0; i < SLIDER_COUNT; i++)
                begin
                    prev_reg[i] <= prev_next[i];
                    cur_reg[i]  <= cur_next[i];
                end
                red_reg        <= red_next;
                green_reg      <= green_next;
                blue_reg       <= blue_next;
                active_reg     <= active_next;
                owner_reg      <= owner_next;
                hold_start_reg <= hold_start_next;
                fading_reg     <= fading_next;
                pending_reg    <= pending_next;
                wr_ptr_reg     <= wr_ptr_reg + PTR_W'(push_cnt);
            end

            // queue pointers
            if (out_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (fire ? CNT_W'(push_cnt) : CNT_W'(0))
                                   - (out_take ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (fire)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
            if (push_cnt == 2'd2)
            begin
                fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/scli_checker.sv
`default_nettype none

module scli_checker
    import scli_pkg::*;
#(
    parameter int SLIDER_COUNT = 5
)
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a dark display has no owner and no colour
    a_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.display_on |->
            out_data.red == '0 && out_data.green == '0 && out_data.blue == '0 &&
            out_data.active_slider == NO_OWNER)
        else $error("colour or owner shown with display off");

    // an owner is always a real slider
    a_owner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.display_on |-> out_data.active_slider < SLIDER_COUNT)
        else $error("owner index out of range");

    // a non-final result is followed at once by the final one
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> out_valid && out_data.last)
        else $error("second result of a fade end missing");

endmodule

bind slider_change_led_indicator_unit scli_checker #(
    .SLIDER_COUNT (SLIDER_COUNT)
) u_scli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
